@@ src/pisl_pkg.sv @@
// ----------------------------------------------------------------------------
// PI speed loop package
// Shared widths, register indexes, reset values and scaling constants.
// ----------------------------------------------------------------------------
package pisl_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_FREQ   = 3'd0,
    CFG_PROP_GAIN     = 3'd1,
    CFG_INT_GAIN      = 3'd2,
    CFG_INT_LIMIT     = 3'd3,
    CFG_FF_DUTY       = 3'd4,
    CFG_TICKS_PER_UPD = 3'd5
  } cfg_idx_e;

  // Item operation codes
  typedef enum logic {
    OP_PULSE = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  // Field widths
  localparam int unsigned ADC_W    = 10;
  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned LIMIT_W  = 10;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned VIN_W    = 15;
  localparam int unsigned VLOGIC_W = 13;
  localparam int unsigned INTEG_W  = 40;
  localparam int unsigned FRAC_W   = 16;

  // Parameter defaults
  localparam int unsigned PWM_MAX_DEF        = 1023;
  localparam int unsigned ADC_FULL_SCALE_DEF = 1024;

  // Register reset values
  localparam logic [FREQ_W-1:0]  TARGET_FREQ_RST = 16'd1200;
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd3277;
  localparam logic [GAIN_W-1:0]  INT_GAIN_RST    = 16'd655;
  localparam logic [LIMIT_W-1:0] INT_LIMIT_RST   = 10'd100;
  localparam logic [DUTY_W-1:0]  FF_DUTY_RST     = 10'd100;
  localparam logic [TICK_W-1:0]  TICKS_UPD_RST   = 8'd10;
  localparam logic [DUTY_W-1:0]  DUTY_RST        = 10'd100;

  // Scaling
  localparam int unsigned FREQ_STEP  = 10;
  localparam int unsigned DUTY_MAX   = 1023;
  localparam longint unsigned VIN_NUM    = 64'd28160;  // 2560 * 11
  localparam longint unsigned VLOGIC_NUM = 64'd99840;  // 2560 * 39
  localparam longint unsigned VLOGIC_DIV = 64'd14;
  localparam int unsigned VIN_MAX    = 32767;
  localparam int unsigned VLOGIC_MAX = 8191;

endpackage

@@ src/pi_speed_loop_with_tacho.sv @@
// ----------------------------------------------------------------------------
// PI speed loop with tachometer
// Counts tacho pulses, runs a fixed-point PI update with anti-windup and
// feedforward every few ticks, and scales converter samples to millivolts.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  in      | in_valid_i / in_ready_o         | request in
//  out     | out_valid_o / out_ready_i       | result out
//  cfg     | cfg_valid_i / cfg_ready_o       | register write in
//
//  One request per cycle; its result is registered and shows the next cycle.
//  The whole update (error, two 17x17 products, integral add) is one stage.
//  A new request is taken while the result slot is empty or being drained.
//  Reset clears control and loop state but duty; config regs take defaults.
//  Config writes are always accepted.
// ----------------------------------------------------------------------------
module pi_speed_loop_with_tacho #(
  parameter int unsigned PWM_MAX        = pisl_pkg::PWM_MAX_DEF,
  parameter int unsigned ADC_FULL_SCALE = pisl_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic [pisl_pkg::ADC_W-1:0]         adc_sample_i,
  input  logic                               motor_running_i,

  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [pisl_pkg::DUTY_W-1:0]        pwm_duty_o,
  output logic [pisl_pkg::FREQ_W-1:0]        measured_frequency_o,
  output logic [pisl_pkg::VIN_W-1:0]         input_voltage_mv_o,
  output logic [pisl_pkg::VLOGIC_W-1:0]      logic_voltage_mv_o,
  output logic                               adc_channel_o,
  output logic                               update_done_o,

  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pisl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pisl_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import pisl_pkg::*;

  // Millivolt scaling: floor(sample * NUM / DIV) as (sample * MUL) >> SHIFT,
  // exact for every ADC_W-bit sample since 2^SHIFT >= 2^ADC_W * DIV.
  localparam longint unsigned VinDiv      = longint'(ADC_FULL_SCALE);
  localparam int unsigned     VinShift    = ADC_W + $clog2(VinDiv);
  localparam longint unsigned VinMul      = ((VIN_NUM << VinShift) + VinDiv - 1) / VinDiv;
  localparam int unsigned     VinMulW     = $clog2(VinMul + 1);
  localparam int unsigned     VinProdW    = ADC_W + VinMulW;

  localparam longint unsigned VlogicDiv   = longint'(ADC_FULL_SCALE) * VLOGIC_DIV;
  localparam int unsigned     VlogicShift = ADC_W + $clog2(VlogicDiv);
  localparam longint unsigned VlogicMul   =
    ((VLOGIC_NUM << VlogicShift) + VlogicDiv - 1) / VlogicDiv;
  localparam int unsigned     VlogicMulW  = $clog2(VlogicMul + 1);
  localparam int unsigned     VlogicProdW = ADC_W + VlogicMulW;

  localparam int unsigned DutyCap  = (PWM_MAX < DUTY_MAX) ? PWM_MAX : DUTY_MAX;
  localparam int unsigned SumW     = INTEG_W + 2;
  localparam int unsigned MagW     = SumW - 1 - FRAC_W;

  // Configuration registers
  logic [FREQ_W-1:0]  target_q;
  logic [GAIN_W-1:0]  prop_gain_q;
  logic [GAIN_W-1:0]  int_gain_q;
  logic [LIMIT_W-1:0] int_limit_q;
  logic [DUTY_W-1:0]  ff_duty_q;
  logic [TICK_W-1:0]  ticks_upd_q;

  // Loop state (duty/freq/voltages/channel double as the result register)
  logic [TICK_W-1:0]         tick_q, tick_d;
  logic [FREQ_W-1:0]         freq_acc_q, freq_acc_d;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic                      chan_q, chan_d;
  logic [DUTY_W-1:0]         duty_q, duty_d;
  logic [FREQ_W-1:0]         freq_q, freq_d;
  logic [VIN_W-1:0]          vin_q, vin_d;
  logic [VLOGIC_W-1:0]       vlogic_q, vlogic_d;
  logic                      done_q, done_d;
  logic                      out_valid_q;

  logic accept;
  logic update;
  logic [TICK_W-1:0] tick_next;

  logic [VinProdW-1:0]    vin_prod, vin_quo;
  logic [VlogicProdW-1:0] vlogic_prod, vlogic_quo;

  logic signed [FREQ_W:0]    err;
  logic signed [2*FREQ_W+1:0] inc, prop_term;
  logic signed [INTEG_W:0]   integ_sum, integ_lim;
  logic signed [INTEG_W-1:0] integ_new;
  logic signed [SumW-1:0]    ctl_sum;
  logic [MagW-1:0]           ctl_mag;
  logic [DUTY_W-1:0]         duty_calc;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  assign tick_next = tick_q + TICK_W'(1);
  // A zero period or a wrapped count also lands on an update
  assign update = (op_e'(operation_i) == OP_TICK) &&
                  ((tick_next >= ticks_upd_q) || (tick_next == '0));

  // Supply monitor scaling
  assign vin_prod    = VinProdW'(adc_sample_i) * VinProdW'(VinMul);
  assign vin_quo     = vin_prod >> VinShift;
  assign vlogic_prod = VlogicProdW'(adc_sample_i) * VlogicProdW'(VlogicMul);
  assign vlogic_quo  = vlogic_prod >> VlogicShift;

  // PI controller, Q.16 fixed point; the freshly measured frequency feeds it
  assign err       = $signed({1'b0, target_q}) - $signed({1'b0, freq_acc_q});
  assign inc       = $signed({1'b0, int_gain_q}) * err;
  assign prop_term = $signed({1'b0, prop_gain_q}) * err;
  assign integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(inc);
  assign integ_lim = $signed({{(INTEG_W+1-LIMIT_W-FRAC_W){1'b0}}, int_limit_q,
                              {FRAC_W{1'b0}}});

  always_comb begin
    integ_new = integ_q;
    if (integ_sum < integ_lim) begin
      // Clamp at the floor of the 40-bit range
      if (integ_sum[INTEG_W] && !integ_sum[INTEG_W-1]) begin
        integ_new = {1'b1, {(INTEG_W-1){1'b0}}};
      end else begin
        integ_new = integ_sum[INTEG_W-1:0];
      end
    end
  end

  assign ctl_sum = SumW'(integ_new) + SumW'(prop_term) +
                   $signed({{(SumW-DUTY_W-FRAC_W){1'b0}}, ff_duty_q, {FRAC_W{1'b0}}});
  assign ctl_mag = ctl_sum[SumW-2:FRAC_W];

  // Negative sums clamp straight to zero, as does a stopped motor
  always_comb begin
    if (!motor_running_i || ctl_sum[SumW-1]) begin
      duty_calc = '0;
    end else if (ctl_mag > MagW'(DutyCap)) begin
      duty_calc = DUTY_W'(DutyCap);
    end else begin
      duty_calc = ctl_mag[DUTY_W-1:0];
    end
  end

  always_comb begin
    tick_d     = tick_q;
    freq_acc_d = freq_acc_q;
    integ_d    = integ_q;
    chan_d     = chan_q;
    duty_d     = duty_q;
    freq_d     = freq_q;
    vin_d      = vin_q;
    vlogic_d   = vlogic_q;
    done_d     = 1'b0;
    if (op_e'(operation_i) == OP_PULSE) begin
      // Count in hertz directly; saturate
      if (freq_acc_q > FREQ_W'((1 << FREQ_W) - 1 - FREQ_STEP)) begin
        freq_acc_d = '1;
      end else begin
        freq_acc_d = freq_acc_q + FREQ_W'(FREQ_STEP);
      end
    end else if (update) begin
      tick_d     = '0;
      freq_acc_d = '0;
      freq_d     = freq_acc_q;
      integ_d    = integ_new;
      duty_d     = duty_calc;
      chan_d     = !chan_q;
      done_d     = 1'b1;
      if (!chan_q) begin
        vin_d = (vin_quo > VinProdW'(VIN_MAX)) ? VIN_W'(VIN_MAX) : vin_quo[VIN_W-1:0];
      end else begin
        vlogic_d = (vlogic_quo > VlogicProdW'(VLOGIC_MAX)) ?
                   VLOGIC_W'(VLOGIC_MAX) : vlogic_quo[VLOGIC_W-1:0];
      end
    end else begin
      tick_d = tick_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      freq_acc_q  <= '0;
      integ_q     <= '0;
      chan_q      <= 1'b0;
      duty_q      <= DUTY_RST;
      freq_q      <= '0;
      vin_q       <= '0;
      vlogic_q    <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        tick_q     <= tick_d;
        freq_acc_q <= freq_acc_d;
        integ_q    <= integ_d;
        chan_q     <= chan_d;
        duty_q     <= duty_d;
        freq_q     <= freq_d;
        vin_q      <= vin_d;
        vlogic_q   <= vlogic_d;
        done_q     <= done_d;
      end
      // Hold the result until taken
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= TARGET_FREQ_RST;
      prop_gain_q <= PROP_GAIN_RST;
      int_gain_q  <= INT_GAIN_RST;
      int_limit_q <= INT_LIMIT_RST;
      ff_duty_q   <= FF_DUTY_RST;
      ticks_upd_q <= TICKS_UPD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET_FREQ:   target_q    <= cfg_data_i[FREQ_W-1:0];
        CFG_PROP_GAIN:     prop_gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_INT_GAIN:      int_gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_INT_LIMIT:     int_limit_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_FF_DUTY:       ff_duty_q   <= cfg_data_i[DUTY_W-1:0];
        CFG_TICKS_PER_UPD: ticks_upd_q <= cfg_data_i[TICK_W-1:0];
        default: ;  // drop unknown indexes
      endcase
    end
  end

  assign out_valid_o          = out_valid_q;
  assign pwm_duty_o           = duty_q;
  assign measured_frequency_o = freq_q;
  assign input_voltage_mv_o   = vin_q;
  assign logic_voltage_mv_o   = vlogic_q;
  assign adc_channel_o        = chan_q;
  assign update_done_o        = done_q;

endmodule

@@ sim/tb_pi_speed_loop_with_tacho.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI speed loop testbench
// Drives tacho pulses and ticks through the request channel, writes the loop
// registers between phases, and checks each result against a fixed status
// or a cycle-free model of the counter, voltage scaling and PI update.
// ----------------------------------------------------------------------------
module tb_pi_speed_loop_with_tacho;
  import pisl_pkg::*;

  localparam int unsigned                 DRAIN_CYCLES  = 4;
  localparam int unsigned                 HOLD_CYCLES   = 60;
  localparam int unsigned                 CYCLE_LIMIT   = 400000;
  localparam logic [CFG_IDX_W-1:0]        CFG_IDX_SPARE = 3'd7;
  localparam logic [12:0]                 PULSE_SAT     = 13'h1FFF;
  localparam longint                      INTEG_FLOOR   = -(64'sd1 <<< 39);
  localparam longint unsigned             ADC_SCALE     = ADC_FULL_SCALE_DEF;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic [FREQ_W-1:0]   freq;
    logic [VIN_W-1:0]    vin_mv;
    logic [VLOGIC_W-1:0] vlogic_mv;
    logic                chan;
    logic                done;
  } loop_status_t;

  typedef struct {
    op_e               op;
    logic [ADC_W-1:0]  sample;
    logic              motor;
    bit                typed;
    loop_status_t      want;
  } dir_row_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic                  operation_i     = 1'b0;
  logic [ADC_W-1:0]      adc_sample_i    = '0;
  logic                  motor_running_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic [DUTY_W-1:0]     pwm_duty_o;
  logic [FREQ_W-1:0]     measured_frequency_o;
  logic [VIN_W-1:0]      input_voltage_mv_o;
  logic [VLOGIC_W-1:0]   logic_voltage_mv_o;
  logic                  adc_channel_o;
  logic                  update_done_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  // Register mirror
  logic [FREQ_W-1:0]  tgt_freq;
  logic [GAIN_W-1:0]  kp;
  logic [GAIN_W-1:0]  ki;
  logic [LIMIT_W-1:0] int_lim;
  logic [DUTY_W-1:0]  ff_duty;
  logic [TICK_W-1:0]  ticks_upd;

  // Loop state
  logic [TICK_W-1:0]   tick_cnt;
  logic [12:0]         pulse_cnt;
  longint              integ;
  logic                chan_sel;
  logic [DUTY_W-1:0]   duty;
  logic [FREQ_W-1:0]   freq;
  logic [VIN_W-1:0]    vin_mv;
  logic [VLOGIC_W-1:0] vlogic_mv;

  loop_status_t status_q[$];
  dir_row_t     dir_rows[$];
  int           mismatches      = 0;
  int unsigned  cycle_count     = 0;
  int           sender_idle_pct = 0;
  int           recv_stall_pct  = 0;
  int           hold_requests   = 0;
  int           hold_served     = 0;
  int           hold_left       = 0;

  pi_speed_loop_with_tacho uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .operation_i          (operation_i),
    .adc_sample_i         (adc_sample_i),
    .motor_running_i      (motor_running_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .pwm_duty_o           (pwm_duty_o),
    .measured_frequency_o (measured_frequency_o),
    .input_voltage_mv_o   (input_voltage_mv_o),
    .logic_voltage_mv_o   (logic_voltage_mv_o),
    .adc_channel_o        (adc_channel_o),
    .update_done_o        (update_done_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void reset_loop_model();
    tgt_freq  = TARGET_FREQ_RST;
    kp        = PROP_GAIN_RST;
    ki        = INT_GAIN_RST;
    int_lim   = INT_LIMIT_RST;
    ff_duty   = FF_DUTY_RST;
    ticks_upd = TICKS_UPD_RST;
    tick_cnt  = '0;
    pulse_cnt = '0;
    integ     = 0;
    chan_sel  = 1'b0;
    duty      = DUTY_RST;
    freq      = '0;
    vin_mv    = '0;
    vlogic_mv = '0;
  endfunction

  // Count pulses; on every period-th tick scale a supply and run the PI update
  function automatic loop_status_t advance_loop(op_e op, logic [ADC_W-1:0] sample,
                                                logic motor);
    loop_status_t    st;
    longint unsigned scaled;
    longint          err;
    longint          inc;
    longint          sum;
    longint          outv;
    st.done = 1'b0;
    if (op == OP_PULSE) begin
      if (pulse_cnt < PULSE_SAT) pulse_cnt = pulse_cnt + 1'b1;
    end else begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= ticks_upd || tick_cnt == 0) begin
        tick_cnt = '0;
        scaled = pulse_cnt * FREQ_STEP;
        freq = (scaled > 65535) ? 16'hFFFF : scaled[FREQ_W-1:0];
        pulse_cnt = '0;
        if (!chan_sel) begin
          scaled = sample * VIN_NUM / ADC_SCALE;
          vin_mv = (scaled > VIN_MAX) ? VIN_MAX[VIN_W-1:0] : scaled[VIN_W-1:0];
          chan_sel = 1'b1;
        end else begin
          scaled = sample * VLOGIC_NUM / ADC_SCALE / VLOGIC_DIV;
          vlogic_mv = (scaled > VLOGIC_MAX) ? VLOGIC_MAX[VLOGIC_W-1:0]
                                            : scaled[VLOGIC_W-1:0];
          chan_sel = 1'b0;
        end
        err = longint'({48'd0, tgt_freq}) - longint'({48'd0, freq});
        inc = longint'({48'd0, ki}) * err;
        // anti-windup: only take the step while it stays under the limit
        if (integ + inc < longint'({54'd0, int_lim}) * 65536) begin
          integ = integ + inc;
          if (integ < INTEG_FLOOR) integ = INTEG_FLOOR;
        end
        sum = longint'({54'd0, ff_duty}) * 65536 + integ + longint'({48'd0, kp}) * err;
        outv = (sum >= 0) ? (sum >>> 16) : -((-sum) >>> 16);
        if (!motor) outv = 0;
        if (outv < 0) outv = 0;
        if (outv > longint'(PWM_MAX_DEF)) outv = longint'(PWM_MAX_DEF);
        if (outv > longint'(DUTY_MAX)) outv = longint'(DUTY_MAX);
        duty = outv[DUTY_W-1:0];
        st.done = 1'b1;
      end
    end
    st.duty      = duty;
    st.freq      = freq;
    st.vin_mv    = vin_mv;
    st.vlogic_mv = vlogic_mv;
    st.chan      = chan_sel;
    return st;
  endfunction

  function automatic void add_row(op_e op, logic [ADC_W-1:0] sample, logic motor,
                                  bit typed);
    dir_row_t r;
    r.op     = op;
    r.sample = sample;
    r.motor  = motor;
    r.typed  = typed;
    r.want   = '0;
    r.want.duty = DUTY_RST;
    dir_rows.push_back(r);
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [ADC_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return ADC_W'($urandom_range(1023));
    endcase
  endfunction

  function automatic logic [FREQ_W-1:0] pick_target();
    if ($urandom_range(4) == 0) return FREQ_W'($urandom_range(65535));
    return FREQ_W'($urandom_range(300));
  endfunction

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    loop_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_q.size() == 0) begin
        $error("result with no pending request");
        mismatches++;
      end else begin
        want = status_q.pop_front();
        check_field("pwm_duty", want.duty, pwm_duty_o);
        check_field("measured_frequency", want.freq, measured_frequency_o);
        check_field("input_voltage_mv", want.vin_mv, input_voltage_mv_o);
        check_field("logic_voltage_mv", want.vlogic_mv, logic_voltage_mv_o);
        check_field("adc_channel", want.chan, adc_channel_o);
        check_field("update_done", want.done, update_done_o);
      end
    end
  end

  task automatic send_item(op_e op, logic [ADC_W-1:0] sample, logic motor,
                           bit typed, loop_status_t want);
    loop_status_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    operation_i     = op;
    adc_sample_i    = sample;
    motor_running_i = motor;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = advance_loop(op, sample, motor);
    status_q.push_back(typed ? want : pred);
  endtask

  // Drop valid so the last request is not taken twice
  task automatic release_input();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_results_drained();
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TARGET_FREQ:   tgt_freq  = data;
      CFG_PROP_GAIN:     kp        = data;
      CFG_INT_GAIN:      ki        = data;
      CFG_INT_LIMIT:     int_lim   = data[LIMIT_W-1:0];
      CFG_FF_DUTY:       ff_duty   = data[DUTY_W-1:0];
      CFG_TICKS_PER_UPD: ticks_upd = data[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [15:0] tgt, logic [15:0] pgain, logic [15:0] igain,
                               logic [15:0] lim, logic [15:0] ff, logic [15:0] tpu);
    write_reg(CFG_TARGET_FREQ, tgt);
    write_reg(CFG_PROP_GAIN, pgain);
    write_reg(CFG_INT_GAIN, igain);
    write_reg(CFG_INT_LIMIT, lim);
    write_reg(CFG_FF_DUTY, ff);
    write_reg(CFG_TICKS_PER_UPD, tpu);
    // unmapped index must leave every register alone
    write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom_range(65535)));
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_random_settings(logic [15:0] tpu);
    load_settings(pick_target(), 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)), tpu);
  endtask

  task automatic run_phase(int n_items, int idle_pct, int stall_pct, bit press);
    loop_status_t none;
    op_e          op;
    none = '0;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (press && i == 20) hold_requests++;
      if (press && i == 50) begin
        release_input();
        wait_results_drained();
      end
      op = ($urandom_range(99) < 35) ? OP_TICK : OP_PULSE;
      send_item(op, pick_sample(), $urandom_range(99) < 85, 1'b0, none);
    end
    release_input();
    wait_results_drained();
  endtask

  initial begin
    loop_status_t none;
    none = '0;
    reset_loop_model();

    // Reset defaults: ten ticks per update, supply channel first
    add_row(OP_PULSE, 10'd0,    1'b0, 1'b1);
    add_row(OP_PULSE, 10'd1023, 1'b1, 1'b1);
    add_row(OP_PULSE, 10'd512,  1'b0, 1'b1);
    for (int i = 0; i < 9; i++)
      add_row(OP_TICK, (i % 2) ? 10'd1023 : 10'd0, 1'(i % 2), 1'b1);
    add_row(OP_TICK, 10'd1023, 1'b1, 1'b0);
    add_row(OP_PULSE, 10'd0, 1'b1, 1'b0);
    add_row(OP_PULSE, 10'd0, 1'b1, 1'b0);
    for (int i = 0; i < 9; i++)
      add_row(OP_TICK, 10'd0, 1'b1, 1'b0);
    // logic channel at full scale with the motor off
    add_row(OP_TICK, 10'd1023, 1'b0, 1'b0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].sample, dir_rows[i].motor,
                dir_rows[i].typed, dir_rows[i].want);
    release_input();
    wait_results_drained();

    load_settings(TARGET_FREQ_RST, PROP_GAIN_RST, INT_GAIN_RST, 16'(INT_LIMIT_RST),
                  16'(FF_DUTY_RST), 16'd1);
    run_phase(80, 0, 0, 1'b0);
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1023, 16'd1023, 16'd2);
    run_phase(80, 50, 0, 1'b0);
    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(80, 0, 50, 1'b0);
    // long period: ticks pile up, then the next phase lowers it
    load_random_settings(16'd255);
    run_phase(60, 18, 18, 1'b0);
    load_random_settings(16'($urandom_range(1, 4)));
    run_phase(80, 18, 18, 1'b1);
    load_random_settings(16'($urandom_range(1, 5)));
    run_phase(80, 0, 0, 1'b0);
    load_random_settings(16'($urandom_range(1, 5)));
    run_phase(80, 50, 0, 1'b0);
    load_random_settings(16'($urandom_range(1, 5)));
    run_phase(80, 0, 50, 1'b0);

    // Burst of pulses, then update twice
    load_random_settings(16'd1);
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    for (int i = 0; i < 20; i++)
      send_item(OP_PULSE, pick_sample(), 1'($urandom_range(1)), 1'b0, none);
    send_item(OP_TICK, 10'd1023, 1'b1, 1'b0, none);
    send_item(OP_TICK, 10'd1023, 1'b1, 1'b0, none);
    release_input();
    wait_results_drained();

    load_random_settings(16'($urandom_range(1, 3)));
    run_phase(20, 18, 18, 1'b0);

    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
src/pisl_pkg.sv
src/pi_speed_loop_with_tacho.sv
sim/tb_pi_speed_loop_with_tacho.sv
